FILE: sv/bkt_pkg.sv
// bkt_pkg: shared types, access codes and constants of the banked tile video register unit
// no dependencies; imported by bkt_fmt and banked_tile_video_register_unit
`default_nettype none

package bkt_pkg;

  // fixed field widths
  localparam int OFF_W  = 14;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 9;

  // access codes carried with each item
  localparam logic [2:0] OP_CTRL_WR   = 3'd0;
  localparam logic [2:0] OP_PAL_RD    = 3'd1;
  localparam logic [2:0] OP_PAL_WR    = 3'd2;
  localparam logic [2:0] OP_VRAM_RD   = 3'd3;
  localparam logic [2:0] OP_VRAM_WR   = 3'd4;
  localparam logic [2:0] OP_SCROLL_WR = 3'd5;
  localparam logic [2:0] OP_TILE      = 3'd6;
  localparam logic [2:0] OP_NONE      = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_TILE_FORMAT = 2'd0;
  localparam logic [1:0] CFG_FLIP_X_OFF  = 2'd1;
  localparam logic [1:0] CFG_FLIP_Y_OFF  = 2'd2;

  // control byte bit positions
  localparam int CTRL_FLIP      = 0;
  localparam int CTRL_VBANK     = 1;
  localparam int CTRL_PBANK     = 6;
  localparam int CTRL_SCROLL0_HI = 3;
  localparam int CTRL_SCROLL1_HI = 2;
  localparam int CTRL_SCROLL2_HI = 5;
  localparam int CTRL_SCROLL3_HI = 4;

  // fixed scroll biases when not flipped
  localparam logic [8:0] SCROLL_X_BIAS = 9'h1f7;
  localparam logic [8:0] SCROLL_Y_BIAS = 9'h0f9;

  // operands of the result formatter
  typedef struct packed {
    logic [7:0]  ctrl;
    logic [1:0]  scroll_sel;
    logic [7:0]  scroll_data;
    logic [8:0]  flip_x_off;
    logic [8:0]  flip_y_off;
    logic        tile_format;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [15:0] pal_word;
  } fmt_in_t;

  // formatted result pieces
  typedef struct packed {
    logic signed [9:0] scroll_value;
    logic [16:0]       tile_code;
    logic [6:0]        tile_color;
    logic [7:0]        pen_red;
    logic [7:0]        pen_green;
    logic [7:0]        pen_blue;
  } fmt_out_t;

  // one result item as it is collected
  typedef struct packed {
    logic [7:0]        read_data;
    logic              pen_write;
    logic [10:0]       pen_index;
    logic [7:0]        pen_red;
    logic [7:0]        pen_green;
    logic [7:0]        pen_blue;
    logic signed [9:0] scroll_value;
    logic [16:0]       tile_code;
    logic [6:0]        tile_color;
  } res_t;

  // 5-bit channel to 8 bits by repeating the top bits
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/bkt_ram.sv
// bkt_ram: single-port synchronous byte memory with registered read data
// no dependencies; holds the video and palette stores
`default_nettype none

module bkt_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire logic          we,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write or read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: sv/bkt_fmt.sv
// bkt_fmt: scroll arithmetic, tile code assembly and pen colour expansion
// depends on bkt_pkg
`default_nettype none

module bkt_fmt (
  input  wire bkt_pkg::fmt_in_t  fin,
  output bkt_pkg::fmt_out_t      fout
);
  import bkt_pkg::*;

  logic       hi;
  logic       is_y;
  logic [8:0] sub;

  // ninth scroll bit from the control byte
  always_comb begin
    unique case (fin.scroll_sel)
      2'd0: hi = fin.ctrl[CTRL_SCROLL0_HI];
      2'd1: hi = fin.ctrl[CTRL_SCROLL1_HI];
      2'd2: hi = fin.ctrl[CTRL_SCROLL2_HI];
      2'd3: hi = fin.ctrl[CTRL_SCROLL3_HI];
      default: hi = 1'b0;
    endcase
  end

  // offset to take off, fixed or configured when flipped
  assign is_y = fin.scroll_sel[0];
  always_comb begin
    if (fin.ctrl[CTRL_FLIP]) begin
      sub = is_y ? fin.flip_y_off : fin.flip_x_off;
    end else begin
      sub = is_y ? SCROLL_Y_BIAS : SCROLL_X_BIAS;
    end
  end

  // scroll value, tile code and colour in either format, rgb555 pen
  always_comb begin
    fout.scroll_value = $signed(10'(fin.scroll_data) + {1'b0, hi, 8'd0} - 10'(sub));
    if (fin.tile_format) begin
      fout.tile_code  = {1'b0, fin.p0, fin.p1};
      fout.tile_color = {1'b0, fin.p2[5:0]};
    end else begin
      fout.tile_code  = {fin.p0[7], fin.p1, fin.p2};
      fout.tile_color = fin.p0[6:0];
    end
    fout.pen_red   = expand5(fin.pal_word[14:10]);
    fout.pen_green = expand5(fin.pal_word[9:5]);
    fout.pen_blue  = expand5(fin.pal_word[4:0]);
  end

endmodule

`default_nettype wire

FILE: sv/banked_tile_video_register_unit.sv
// banked_tile_video_register_unit: top level, access sequencer over video and palette stores
// depends on bkt_pkg, bkt_ram and bkt_fmt
//
// channel   dir  transfer       payload
// s_axis    in   tvalid&tready  tdata: offset, data   tuser: opcode, layer
// m_axis    out  tvalid&tready  tdata: result fields  tuser: pen_write
// cfg       in   valid&ready    index, data (always ready outside reset)
//
// control, scroll, unused codes and out-of-range video access go straight to emit; video
// writes pass the access state, reads also the done state; palette and tile items first
// reduce the offset by the bank or plane size (one subtract a cycle), then pass the
// palette access and done states or the tile fetch and end states. a clearing pass after
// reset zeroes both stores and takes no item. a result waits in the output register while
// the next item is taken; a stalled output holds the sequencer before its next result.
`default_nettype none

module banked_tile_video_register_unit #(
  parameter int LAYER_BYTES   = 12288,
  parameter int PALETTE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // offset[13:0], data[21:14], zero pad
  input  wire logic [3:0]  s_axis_tuser,   // opcode[2:0], layer[3]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // read_data, pen_index, pen_red, pen_green,
                                           // pen_blue, flip, scroll_value, tile_code,
                                           // tile_color, zero pad
  output logic             m_axis_tuser,   // pen_write
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [bkt_pkg::CFG_W-1:0] cfg_data
);
  import bkt_pkg::*;

  // store geometry
  localparam int PLANE_BYTES = LAYER_BYTES / 3;
  localparam int PBANK_BYTES = PALETTE_BYTES / 2;
  localparam int V_DEPTH     = 2 * LAYER_BYTES;
  localparam int VAW         = $clog2(V_DEPTH);
  localparam int PAW         = $clog2(PALETTE_BYTES);
  localparam int CLR_N       = (V_DEPTH > PALETTE_BYTES) ? V_DEPTH : PALETTE_BYTES;
  localparam int CLR_W       = $clog2(CLR_N);
  localparam int RED_W       = ($clog2(PLANE_BYTES + 1) > OFF_W) ?
                               $clog2(PLANE_BYTES + 1) : OFF_W;

  localparam logic [RED_W-1:0] PLANE_M = RED_W'(PLANE_BYTES);
  localparam logic [RED_W-1:0] PBANK_M = RED_W'(PBANK_BYTES);
  localparam logic [VAW-1:0]   LAYER_V = VAW'(LAYER_BYTES);
  localparam logic [VAW-1:0]   PLANE_V = VAW'(PLANE_BYTES);
  localparam logic [PAW-1:0]   PBANK_P = PAW'(PBANK_BYTES);

  // sequencer states
  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_REDUCE    = 4'd2;
  localparam logic [3:0] S_PAL_ACC   = 4'd3;
  localparam logic [3:0] S_PAL_DONE  = 4'd4;
  localparam logic [3:0] S_VRAM_ACC  = 4'd5;
  localparam logic [3:0] S_VRAM_DONE = 4'd6;
  localparam logic [3:0] S_TILE_P0   = 4'd7;
  localparam logic [3:0] S_TILE_P1   = 4'd8;
  localparam logic [3:0] S_TILE_P2   = 4'd9;
  localparam logic [3:0] S_TILE_END  = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic [7:0]       ctrl;
  logic             tile_format;
  logic [8:0]       flip_x_off;
  logic [8:0]       flip_y_off;

  logic [2:0]       op;
  logic [7:0]       data_q;
  logic             layer_q;
  logic [RED_W-1:0] red;
  logic [VAW-1:0]   vaddr;
  logic [PAW-1:0]   paddr;
  logic [7:0]       p0;
  logic [7:0]       p1;
  res_t             res;

  logic [2:0]       in_op;
  logic             in_layer;
  logic [OFF_W-1:0] in_off;
  logic [7:0]       in_data;
  logic             s_acc;
  logic             out_free;
  logic             clr_last;
  logic             vram_in_range;
  logic             scroll_ok;
  logic [RED_W-1:0] modulus;
  logic             red_ge;
  logic [VAW-1:0]   vram_base;
  logic [VAW-1:0]   tile_base;
  logic [PAW-1:0]   pal_base;
  res_t             res_first;

  logic [VAW-1:0]   v_addr;
  logic             v_we;
  logic [7:0]       v_wdata;
  logic [7:0]       v_rdata;
  logic [PAW-1:0]   p_addr;
  logic             p_we;
  logic [7:0]       p_wdata;
  logic [7:0]       p_rdata;

  fmt_in_t          fin;
  fmt_out_t         fout;

  // port unpacking and handshakes
  assign in_off        = s_axis_tdata[13:0];
  assign in_data       = s_axis_tdata[21:14];
  assign in_op         = s_axis_tuser[2:0];
  assign in_layer      = s_axis_tuser[3];
  assign s_axis_tready = (state == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready     = !rst;

  // address arithmetic
  assign clr_last      = (clr_cnt == CLR_W'(CLR_N - 1));
  assign vram_in_range = (32'(in_off) < 32'(LAYER_BYTES));
  assign scroll_ok     = (in_off[OFF_W-1:2] == '0);
  assign modulus       = (op == OP_TILE) ? PLANE_M : PBANK_M;
  assign red_ge        = (red >= modulus);
  assign vram_base     = ctrl[CTRL_VBANK] ? '0 : LAYER_V;
  assign tile_base     = (layer_q ? LAYER_V : '0) + VAW'(red);
  assign pal_base      = (ctrl[CTRL_PBANK] ? PBANK_P : '0) + PAW'(red);

  // formatter operands
  always_comb begin
    fin.ctrl        = ctrl;
    fin.scroll_sel  = in_off[1:0];
    fin.scroll_data = in_data;
    fin.flip_x_off  = flip_x_off;
    fin.flip_y_off  = flip_y_off;
    fin.tile_format = tile_format;
    fin.p0          = p0;
    fin.p1          = p1;
    fin.p2          = v_rdata;
    fin.pal_word    = paddr[0] ? {data_q, p_rdata} : {p_rdata, data_q};
  end

  bkt_fmt u_fmt (
    .fin  (fin),
    .fout (fout)
  );

  // result as it starts, with the scroll value already known
  always_comb begin
    res_first = '0;
    if (in_op == OP_SCROLL_WR && scroll_ok) begin
      res_first.scroll_value = fout.scroll_value;
    end
  end

  // memory port control
  always_comb begin
    v_addr  = vaddr;
    v_we    = 1'b0;
    v_wdata = data_q;
    p_addr  = paddr;
    p_we    = 1'b0;
    p_wdata = data_q;
    unique case (state)
      S_CLEAR: begin
        v_addr  = VAW'(clr_cnt);
        v_we    = (32'(clr_cnt) < 32'(V_DEPTH));
        v_wdata = '0;
        p_addr  = PAW'(clr_cnt);
        p_we    = (32'(clr_cnt) < 32'(PALETTE_BYTES));
        p_wdata = '0;
      end
      S_PAL_ACC: begin
        if (op == OP_PAL_WR) begin
          p_addr = paddr ^ PAW'(1);
        end
      end
      S_PAL_DONE: begin
        p_we = (op == OP_PAL_WR);
      end
      S_VRAM_ACC: begin
        v_we = (op == OP_VRAM_WR);
      end
      default: begin
      end
    endcase
  end

  bkt_ram #(.DEPTH(V_DEPTH)) u_vram (
    .clk   (clk),
    .addr  (v_addr),
    .we    (v_we),
    .wdata (v_wdata),
    .rdata (v_rdata)
  );

  bkt_ram #(.DEPTH(PALETTE_BYTES)) u_pal (
    .clk   (clk),
    .addr  (p_addr),
    .we    (p_we),
    .wdata (p_wdata),
    .rdata (p_rdata)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          unique case (in_op)
            OP_PAL_RD, OP_PAL_WR, OP_TILE: state_next = S_REDUCE;
            OP_VRAM_RD, OP_VRAM_WR: state_next = vram_in_range ? S_VRAM_ACC : S_EMIT;
            OP_CTRL_WR, OP_SCROLL_WR, OP_NONE: state_next = S_EMIT;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_REDUCE: begin
        if (!red_ge) begin
          state_next = (op == OP_TILE) ? S_TILE_P0 : S_PAL_ACC;
        end
      end
      S_PAL_ACC:   state_next = S_PAL_DONE;
      S_PAL_DONE:  state_next = S_EMIT;
      S_VRAM_ACC:  state_next = (op == OP_VRAM_RD) ? S_VRAM_DONE : S_EMIT;
      S_VRAM_DONE: state_next = S_EMIT;
      S_TILE_P0:   state_next = S_TILE_P1;
      S_TILE_P1:   state_next = S_TILE_P2;
      S_TILE_P2:   state_next = S_TILE_END;
      S_TILE_END:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      ctrl          <= '0;
      tile_format   <= 1'b0;
      flip_x_off    <= '0;
      flip_y_off    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (s_acc && in_op == OP_CTRL_WR) begin
        ctrl <= in_data;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TILE_FORMAT: tile_format <= cfg_data[0];
          CFG_FLIP_X_OFF:  flip_x_off  <= cfg_data;
          CFG_FLIP_Y_OFF:  flip_y_off  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // item payload and result collection
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          op      <= in_op;
          data_q  <= in_data;
          layer_q <= in_layer;
          red     <= RED_W'(in_off);
          vaddr   <= vram_base + VAW'(in_off);
          res     <= res_first;
        end
      end
      S_REDUCE: begin
        if (red_ge) begin
          red <= red - modulus;
        end else begin
          vaddr <= tile_base;
          paddr <= pal_base;
        end
      end
      S_PAL_DONE: begin
        if (op == OP_PAL_WR) begin
          res.pen_write <= 1'b1;
          res.pen_index <= 11'(paddr >> 1);
          res.pen_red   <= fout.pen_red;
          res.pen_green <= fout.pen_green;
          res.pen_blue  <= fout.pen_blue;
        end else begin
          res.read_data <= p_rdata;
        end
      end
      S_VRAM_DONE: begin
        res.read_data <= v_rdata;
      end
      S_TILE_P0: begin
        vaddr <= vaddr + PLANE_V;
      end
      S_TILE_P1: begin
        p0    <= v_rdata;
        vaddr <= vaddr + PLANE_V;
      end
      S_TILE_P2: begin
        p1 <= v_rdata;
      end
      S_TILE_END: begin
        res.tile_code  <= fout.tile_code;
        res.tile_color <= fout.tile_color;
      end
      S_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {2'b00, res.tile_color, res.tile_code, res.scroll_value,
                           ctrl[CTRL_FLIP], res.pen_blue, res.pen_green, res.pen_red,
                           res.pen_index, res.read_data};
          m_axis_tuser <= res.pen_write;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  // reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("clearing pass not started after reset");

  // an accepted item leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> state != S_IDLE)
    else $error("sequencer stayed idle after accepting an item");

  // a result handed over raises the output valid
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> m_axis_tvalid)
    else $error("result lost at the output register");

  // the subtract loop ends with the index below its modulus
  a_reduce_done: assert property (@(posedge clk) disable iff (rst)
    state == S_REDUCE && !red_ge |=> red < $past(modulus))
    else $error("offset reduction left an out-of-range index");
`endif

endmodule

`default_nettype wire
